// ----- src/dec_pkg.sv -----
package dec_pkg;

  // Fixed-point formats
  localparam int NFRAC = 28;        // unit normal scale, Q2.28; also the shift after weighting
  localparam int WFRAC = 29;        // mass weight scale, carries the factor 2.0
  localparam int QUEUE_DEPTH = 4;

  // Datapath widths
  localparam int VW = 32;           // velocity / position
  localparam int MW = 31;           // mass / diameter / distance magnitude
  localparam int DSQ_W = 2 * MW + 1;
  localparam int ROOT_W = 32;
  localparam int NQ_W = NFRAC + 1;  // |n| <= 2^28
  localparam int WQ_W = WFRAC + 1;  // w <= 2^29
  localparam int N_W = NQ_W + 1;    // signed normal
  localparam int BACK_LAT = 71;     // stages from queue head to last side tap

  // Weight used when both masses are zero
  localparam logic [WQ_W-1:0] W_EQUAL = WQ_W'(1) << (WFRAC - 1);

  typedef struct packed {
    logic signed [VW-1:0] a_pos_x;
    logic signed [VW-1:0] a_pos_y;
    logic signed [VW-1:0] a_vel_x;
    logic signed [VW-1:0] a_vel_y;
    logic [MW-1:0]        a_diameter;
    logic [MW-1:0]        a_mass;
    logic signed [VW-1:0] b_pos_x;
    logic signed [VW-1:0] b_pos_y;
    logic signed [VW-1:0] b_vel_x;
    logic signed [VW-1:0] b_vel_y;
    logic [MW-1:0]        b_diameter;
    logic [MW-1:0]        b_mass;
  } item_t;

  typedef struct packed {
    logic signed [VW-1:0] new_a_vel_x;
    logic signed [VW-1:0] new_a_vel_y;
    logic signed [VW-1:0] new_b_vel_x;
    logic signed [VW-1:0] new_b_vel_y;
    logic                 hit;
  } result_t;

  // Classified pair handed from front to back
  typedef struct packed {
    logic                 hit;
    logic signed [VW-1:0] avx;
    logic signed [VW-1:0] avy;
    logic signed [VW-1:0] bvx;
    logic signed [VW-1:0] bvy;
    logic [MW-1:0]        amass;
    logic [MW-1:0]        bmass;
    logic [VW-1:0]        tot;
    logic                 sdx;
    logic                 sdy;
    logic [MW-1:0]        adx;
    logic [MW-1:0]        ady;
    logic [DSQ_W-1:0]     dsq;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/dec_div.sv -----
module dec_div #(
  parameter int NW = 59,
  parameter int DW = 32,
  parameter int QW = 29
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0] rem_q [1:QW];
  logic [DW-1:0] den_q [1:QW];
  logic [QW-1:0] quo_q [1:QW];

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int K = QW - j;
    logic [RW-1:0] rin;
    logic [RW-1:0] sh;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;

    if (j == 1) begin : g_first
      assign rin = RW'(num);
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign din = den_q[j-1];
      assign qin = quo_q[j-1];
    end

    assign sh = RW'(din) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[j] <= din;
        if (rin >= sh) begin
          rem_q[j] <= rin - sh;
          quo_q[j] <= qin | (QW'(1) << K);
        end else begin
          rem_q[j] <= rin;
          quo_q[j] <= qin;
        end
      end
    end
  end

  assign quo = quo_q[QW];

endmodule

// ----- src/dec_front.sv -----
module dec_front (
  input  logic                clk,
  input  logic                rst,
  input  dec_pkg::item_t      item,
  input  logic                item_valid,
  output logic                item_stall,
  input  dec_pkg::q_stat_t    q_stat,
  output logic                push,
  output dec_pkg::pair_t      pair
);

  localparam int VW = dec_pkg::VW;
  localparam int MW = dec_pkg::MW;

  logic v1, v2, v3, v4;
  logic en;

  dec_pkg::item_t it1, it2, it3;
  logic signed [VW:0] dx1, dy1;
  logic [VW-1:0] s1, tot1, s2, tot2, tot3;
  logic inr2, sdx2, sdy2, inr3, sdx3, sdy3;
  logic [MW-1:0] adx2, ady2, adx3, ady3;
  logic [2*MW-1:0] sqx3, sqy3;
  logic [2*VW-1:0] ss3;
  logic [dec_pkg::DSQ_W-1:0] dsq;
  logic hit;

  // Whole front advances unless the last stage is blocked by a full queue
  assign en = !(v4 && q_stat.full);
  assign item_stall = !en;
  assign push = v4 && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: center deltas, diameter sum, mass sum
  always_ff @(posedge clk) begin
    if (en) begin
      it1  <= item;
      dx1  <= (VW+1)'(item.a_pos_x) - (VW+1)'(item.b_pos_x);
      dy1  <= (VW+1)'(item.a_pos_y) - (VW+1)'(item.b_pos_y);
      s1   <= VW'(item.a_diameter) + VW'(item.b_diameter);
      tot1 <= VW'(item.a_mass) + VW'(item.b_mass);
    end
  end

  // Stage 2: range check and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      it2  <= it1;
      s2   <= s1;
      tot2 <= tot1;
      inr2 <= ((dx1[VW:VW-1] == 2'b00) || (dx1[VW:VW-1] == 2'b11 && dx1[VW-2:0] != '0)) &&
              ((dy1[VW:VW-1] == 2'b00) || (dy1[VW:VW-1] == 2'b11 && dy1[VW-2:0] != '0));
      sdx2 <= dx1[VW];
      sdy2 <= dy1[VW];
      adx2 <= dx1[VW] ? MW'(-dx1) : MW'(dx1);
      ady2 <= dy1[VW] ? MW'(-dy1) : MW'(dy1);
    end
  end

  // Stage 3: squares
  always_ff @(posedge clk) begin
    if (en) begin
      it3  <= it2;
      tot3 <= tot2;
      inr3 <= inr2;
      sdx3 <= sdx2;
      sdy3 <= sdy2;
      adx3 <= adx2;
      ady3 <= ady2;
      sqx3 <= {{MW{1'b0}}, adx2} * {{MW{1'b0}}, adx2};
      sqy3 <= {{MW{1'b0}}, ady2} * {{MW{1'b0}}, ady2};
      ss3  <= {{VW{1'b0}}, s2} * {{VW{1'b0}}, s2};
    end
  end

  // Stage 4: distance squared and overlap test, 4*D < S*S
  always_comb begin
    dsq = dec_pkg::DSQ_W'(sqx3) + dec_pkg::DSQ_W'(sqy3);
    hit = inr3 && (dsq != '0) && ({dsq, 2'b00} < {1'b0, ss3});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair.hit   <= hit;
      pair.avx   <= it3.a_vel_x;
      pair.avy   <= it3.a_vel_y;
      pair.bvx   <= it3.b_vel_x;
      pair.bvy   <= it3.b_vel_y;
      pair.amass <= it3.a_mass;
      pair.bmass <= it3.b_mass;
      pair.tot   <= tot3;
      pair.sdx   <= sdx3;
      pair.sdy   <= sdy3;
      pair.adx   <= adx3;
      pair.ady   <= ady3;
      pair.dsq   <= dsq;
    end
  end

endmodule

// ----- src/dec_queue.sv -----
module dec_queue #(
  parameter int QDEPTH = dec_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dec_pkg::pair_t   wdata,
  input  logic             pop,
  output dec_pkg::pair_t   rdata,
  output dec_pkg::q_stat_t q_stat
);

  localparam int AW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  dec_pkg::pair_t mem [QDEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr];
  assign q_stat.full  = (count == CW'(QDEPTH));
  assign q_stat.empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ----- src/dec_back.sv -----
module dec_back (
  input  logic              clk,
  input  logic              rst,
  input  dec_pkg::pair_t    pair,
  input  dec_pkg::q_stat_t  q_stat,
  output logic              pop,
  output dec_pkg::result_t  result,
  output logic              result_valid,
  input  logic              result_stall
);

  localparam int VW    = dec_pkg::VW;
  localparam int NFRAC = dec_pkg::NFRAC;
  localparam int WFRAC = dec_pkg::WFRAC;
  localparam int RTW   = dec_pkg::ROOT_W;
  localparam int LAT   = dec_pkg::BACK_LAT;
  localparam int NQ_W  = dec_pkg::NQ_W;
  localparam int WQ_W  = dec_pkg::WQ_W;
  localparam int N_W   = dec_pkg::N_W;
  localparam int DSQ_W = dec_pkg::DSQ_W;
  localparam int PV_W  = VW + N_W;        // v * n
  localparam int SV_W  = PV_W + 1;        // sum of two
  localparam int VN_W  = VW + 2;          // normal velocity
  localparam int DV_W  = VN_W + 1;
  localparam int PD_W  = DV_W + WQ_W + 1; // w * dv
  localparam int D_W   = DV_W + 1;        // velocity change along normal
  localparam int PT_W  = D_W + N_W;       // d * n
  localparam int T_W   = D_W;
  localparam int S_W   = T_W + 1;
  // Tap points along the side line
  localparam int T_SQRT = RTW;            // root ready
  localparam int T_MDIV = T_SQRT - 1;     // mass divider start
  localparam int T_DIV  = T_SQRT + NQ_W;  // quotients ready

  localparam logic signed [SV_W-1:0] BIAS_SV = (SV_W'(1) <<< NFRAC) - SV_W'(1);
  localparam logic signed [PD_W-1:0] BIAS_PD = (PD_W'(1) <<< NFRAC) - PD_W'(1);
  localparam logic signed [PT_W-1:0] BIAS_PT = (PT_W'(1) <<< NFRAC) - PT_W'(1);
  localparam logic signed [S_W-1:0]  SAT_MAX = S_W'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [S_W-1:0]  SAT_MIN = -S_W'({1'b0, {(VW-1){1'b1}}}) - S_W'(1);

  logic en;
  logic vld [0:LAT-1];
  dec_pkg::pair_t side [0:LAT-1];

  logic [DSQ_W-1:0] rem_q  [1:RTW];
  logic [RTW-1:0]   root_q [1:RTW];

  logic [NQ_W-1:0] qx, qy;
  logic [WQ_W-1:0] qa, qb;

  logic signed [N_W-1:0] nx_d [1:7];
  logic signed [N_W-1:0] ny_d [1:7];
  logic [WQ_W-1:0] wa_d [1:5];
  logic [WQ_W-1:0] wb_d [1:5];

  logic signed [PV_W-1:0] pax, pay, pbx, pby;
  logic signed [SV_W-1:0] suma, sumb, ta, tb;
  logic signed [VN_W-1:0] vna, vnb;
  logic signed [DV_W-1:0] dv, ndv;
  logic signed [PD_W-1:0] pda, pdb, tda, tdb;
  logic signed [D_W-1:0]  da, db;
  logic signed [PT_W-1:0] tax, tay, tbx, tby, rax, ray, rbx, rby;
  logic signed [T_W-1:0]  cax, cay, cbx, cby;

  function automatic logic signed [VW-1:0] sat(input logic signed [S_W-1:0] x);
    if (x > SAT_MAX) begin
      return SAT_MAX[VW-1:0];
    end else if (x < SAT_MIN) begin
      return SAT_MIN[VW-1:0];
    end
    return x[VW-1:0];
  endfunction

  // Whole back pipeline holds only when the result register is stalled
  assign en  = !(result_valid && result_stall);
  assign pop = en && !q_stat.empty;

  // Valid line and side data line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld[i] <= 1'b0;
      end
      result_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= pop;
      for (int i = 1; i < LAT; i++) begin
        vld[i] <= vld[i-1];
      end
      result_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= pair;
      for (int i = 1; i < LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // Integer square root of distance squared, one root bit per stage
  for (genvar j = 1; j <= RTW; j++) begin : g_sqrt
    localparam int K = RTW - j;
    logic [DSQ_W-1:0] rin;
    logic [RTW-1:0]   oin;
    logic [DSQ_W+1:0] trial;

    if (j == 1) begin : g_first
      assign rin = side[0].dsq;
      assign oin = '0;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign oin = root_q[j-1];
    end

    assign trial = ((DSQ_W+2)'(oin) << (K + 1)) | ((DSQ_W+2)'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'b00, rin} >= trial) begin
          rem_q[j]  <= DSQ_W'({2'b00, rin} - trial);
          root_q[j] <= oin | (RTW'(1) << K);
        end else begin
          rem_q[j]  <= rin;
          root_q[j] <= oin;
        end
      end
    end
  end

  // Unit normal magnitudes: |d| * 2^28 / dist
  dec_div #(.NW(dec_pkg::MW + NFRAC), .DW(RTW), .QW(NQ_W)) u_div_nx (
    .clk (clk),
    .en  (en),
    .num ({side[T_SQRT].adx, {NFRAC{1'b0}}}),
    .den (root_q[RTW]),
    .quo (qx)
  );

  dec_div #(.NW(dec_pkg::MW + NFRAC), .DW(RTW), .QW(NQ_W)) u_div_ny (
    .clk (clk),
    .en  (en),
    .num ({side[T_SQRT].ady, {NFRAC{1'b0}}}),
    .den (root_q[RTW]),
    .quo (qy)
  );

  // Mass weights: m * 2^29 / (ma + mb)
  dec_div #(.NW(dec_pkg::MW + WFRAC), .DW(VW), .QW(WQ_W)) u_div_wa (
    .clk (clk),
    .en  (en),
    .num ({side[T_MDIV].amass, {WFRAC{1'b0}}}),
    .den (side[T_MDIV].tot),
    .quo (qa)
  );

  dec_div #(.NW(dec_pkg::MW + WFRAC), .DW(VW), .QW(WQ_W)) u_div_wb (
    .clk (clk),
    .en  (en),
    .num ({side[T_MDIV].bmass, {WFRAC{1'b0}}}),
    .den (side[T_MDIV].tot),
    .quo (qb)
  );

  // Rounding toward zero on the shifts by 2^28
  always_comb begin
    ta  = suma + (suma[SV_W-1] ? BIAS_SV : '0);
    tb  = sumb + (sumb[SV_W-1] ? BIAS_SV : '0);
    tda = pda + (pda[PD_W-1] ? BIAS_PD : '0);
    tdb = pdb + (pdb[PD_W-1] ? BIAS_PD : '0);
    rax = tax + (tax[PT_W-1] ? BIAS_PT : '0);
    ray = tay + (tay[PT_W-1] ? BIAS_PT : '0);
    rbx = tbx + (tbx[PT_W-1] ? BIAS_PT : '0);
    rby = tby + (tby[PT_W-1] ? BIAS_PT : '0);
  end

  // Response datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // signed normal, weights
      nx_d[1] <= side[T_DIV].sdx ? -N_W'(qx) : N_W'(qx);
      ny_d[1] <= side[T_DIV].sdy ? -N_W'(qy) : N_W'(qy);
      wa_d[1] <= (side[T_DIV].tot == '0) ? dec_pkg::W_EQUAL : qa;
      wb_d[1] <= (side[T_DIV].tot == '0) ? dec_pkg::W_EQUAL : qb;
      for (int i = 2; i <= 7; i++) begin
        nx_d[i] <= nx_d[i-1];
        ny_d[i] <= ny_d[i-1];
      end
      for (int i = 2; i <= 5; i++) begin
        wa_d[i] <= wa_d[i-1];
        wb_d[i] <= wb_d[i-1];
      end
      // projections onto the normal
      pax  <= side[T_DIV+1].avx * nx_d[1];
      pay  <= side[T_DIV+1].avy * ny_d[1];
      pbx  <= side[T_DIV+1].bvx * nx_d[1];
      pby  <= side[T_DIV+1].bvy * ny_d[1];
      suma <= SV_W'(pax) + SV_W'(pay);
      sumb <= SV_W'(pbx) + SV_W'(pby);
      vna  <= VN_W'(ta >>> NFRAC);
      vnb  <= VN_W'(tb >>> NFRAC);
      dv   <= DV_W'(vnb) - DV_W'(vna);
      ndv  <= DV_W'(vna) - DV_W'(vnb);
      // mass-weighted exchange along the normal
      pda  <= $signed({1'b0, wb_d[5]}) * dv;
      pdb  <= $signed({1'b0, wa_d[5]}) * ndv;
      da   <= D_W'(tda >>> NFRAC);
      db   <= D_W'(tdb >>> NFRAC);
      tax  <= da * nx_d[7];
      tay  <= da * ny_d[7];
      tbx  <= db * nx_d[7];
      tby  <= db * ny_d[7];
      cax  <= T_W'(rax >>> NFRAC);
      cay  <= T_W'(ray >>> NFRAC);
      cbx  <= T_W'(rbx >>> NFRAC);
      cby  <= T_W'(rby >>> NFRAC);
    end
  end

  // Result register: add, saturate, or pass through on no hit
  always_ff @(posedge clk) begin
    if (en) begin
      result.hit <= side[LAT-1].hit;
      if (side[LAT-1].hit) begin
        result.new_a_vel_x <= sat(S_W'(side[LAT-1].avx) + S_W'(cax));
        result.new_a_vel_y <= sat(S_W'(side[LAT-1].avy) + S_W'(cay));
        result.new_b_vel_x <= sat(S_W'(side[LAT-1].bvx) + S_W'(cbx));
        result.new_b_vel_y <= sat(S_W'(side[LAT-1].bvy) + S_W'(cby));
      end else begin
        result.new_a_vel_x <= side[LAT-1].avx;
        result.new_a_vel_y <= side[LAT-1].avy;
        result.new_b_vel_x <= side[LAT-1].bvx;
        result.new_b_vel_y <= side[LAT-1].bvy;
      end
    end
  end

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
      vld[T_SQRT] && side[T_SQRT].hit |-> root_q[RTW] != '0)
    else $error("zero distance on a hit");
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
      vld[T_DIV+1] && side[T_DIV+1].hit |->
      ({1'b0, wa_d[1]} + {1'b0, wb_d[1]}) <= ((WQ_W+1)'(1) << WFRAC))
    else $error("mass weights exceed two");
  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
      en && vld[LAT-1] |=> result_valid)
    else $error("result lost at output register");

endmodule

// ----- src/disc_elastic_collision.sv -----
// Elastic response for one pair of discs per transaction: positions, velocities,
// diameters and masses in Q16.16 go in, new velocities plus a hit flag come out,
// one result per transaction and in order. A new pair is taken every cycle while
// item_stall is low. A pair passes 4 front stages for the overlap test, the queue
// and 72 back stages; the back depth is set by the 32-stage square root and
// the 29-stage normal divider in series in the back pipeline. A short queue
// sits between the overlap test and the response pipeline, so a stalled result
// holds the back end while the front keeps accepting until the queue fills.
module disc_elastic_collision #(
  parameter int QDEPTH = dec_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  dec_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_stall,
  output dec_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall
);

  dec_pkg::pair_t   f_pair, q_pair;
  dec_pkg::q_stat_t q_stat;
  logic             push, pop;

  dec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .q_stat     (q_stat),
    .push       (push),
    .pair       (f_pair)
  );

  dec_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (f_pair),
    .pop    (pop),
    .rdata  (q_pair),
    .q_stat (q_stat)
  );

  dec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pair         (q_pair),
    .q_stat       (q_stat),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
